[rtl/dhfk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared types, fixed-point constants and helpers for the DH kinematics core.
// ----------------------------------------------------------------------------
package dhfk_pkg;

    localparam int NUM_JOINTS   = 6;
    localparam int NUM_REGS     = 6;
    localparam int ANG_W        = 18;
    localparam int LEN_W        = 24;
    localparam int ATAN_ENTRIES = 24;
    localparam int ROT_W        = 18;
    localparam int POS_W        = 28;

    typedef logic signed [31:0]      t_q28;
    typedef logic signed [32:0]      t_pos;
    typedef logic signed [ANG_W-1:0] t_ang_in;
    typedef t_q28                    t_lane [NUM_JOINTS];
    typedef t_ang_in                 t_ang_lane [NUM_JOINTS];
    typedef t_q28                    t_rot [3][3];
    typedef t_pos                    t_vec [3];

    localparam t_q28 Q28_ONE     = 32'sd268435456;
    localparam t_q28 Q28_PI_HALF = 32'sd421657428;
    localparam t_q28 Q28_PI      = 32'sd843314857;
    localparam t_q28 Q28_TWO_PI  = 32'sd1686629713;
    localparam t_q28 Q28_GAIN    = 32'sd163008219;

    localparam t_q28 ATAN_Q28 [ATAN_ENTRIES] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    // twist cosine / sine per joint
    localparam logic signed [1:0] JOINT_CA [NUM_JOINTS] = '{
        2'sd0, 2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd1
    };
    localparam logic signed [1:0] JOINT_SA [NUM_JOINTS] = '{
        2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, 2'sd0
    };
    localparam t_q28 JOINT_OFFSET [NUM_JOINTS] = '{
        32'sd0, Q28_PI_HALF, 32'sd0, 32'sd0, 32'sd0, 32'sd0
    };

    localparam logic [2:0] REG_BASE_HEIGHT      = 3'd0;
    localparam logic [2:0] REG_SHOULDER_OFFSET  = 3'd1;
    localparam logic [2:0] REG_UPPER_ARM_LENGTH = 3'd2;
    localparam logic [2:0] REG_ELBOW_OFFSET     = 3'd3;
    localparam logic [2:0] REG_FOREARM_LENGTH   = 3'd4;
    localparam logic [2:0] REG_TOOL_LENGTH      = 3'd5;

    localparam logic signed [66:0] HALF_Q28 = 67'sd134217728;

    function automatic logic signed [65:0] apply_sign(input logic signed [1:0] k,
                                                       input logic signed [65:0] v);
        logic signed [65:0] r;
        case (k)
            2'sd1:   r = v;
            -2'sd1:  r = -v;
            default: r = '0;
        endcase
        return r;
    endfunction

    // round half up, then drop 28 fraction bits
    function automatic t_q28 rnd_q28(input logic signed [66:0] v);
        logic signed [66:0] t;
        t = v + HALF_Q28;
        return t_q28'(t[59:28]);
    endfunction

    function automatic t_pos rnd_pos(input logic signed [66:0] v);
        logic signed [66:0] t;
        t = v + HALF_Q28;
        return t_pos'(t[60:28]);
    endfunction

endpackage

[rtl/dhfk_fold.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_fold
// Two-stage angle reduction for all joints: Q2.15 to Q.28, wrap by 2*pi,
// then fold into [-pi/2, pi/2] with a sign flag.
// ----------------------------------------------------------------------------
module dhfk_fold import dhfk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_ang_lane             i_ang,
    output logic                  o_valid,
    output t_lane                 o_z,
    output logic [NUM_JOINTS-1:0] o_flip
);

    logic                  r_valid1, r_valid2;
    t_lane                 r_t1, n_t1, r_z, n_z;
    logic [NUM_JOINTS-1:0] r_flip, n_flip;

    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            t_q28 th;
            th = (t_q28'(i_ang[j]) <<< 13) + JOINT_OFFSET[j];
            if (th > Q28_PI) begin
                n_t1[j] = th - Q28_TWO_PI;
            end else if (th < -Q28_PI) begin
                n_t1[j] = th + Q28_TWO_PI;
            end else begin
                n_t1[j] = th;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            if (r_t1[j] > Q28_PI_HALF) begin
                n_z[j]    = r_t1[j] - Q28_PI;
                n_flip[j] = 1'b1;
            end else if (r_t1[j] < -Q28_PI_HALF) begin
                n_z[j]    = r_t1[j] + Q28_PI;
                n_flip[j] = 1'b1;
            end else begin
                n_z[j]    = r_t1[j];
                n_flip[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1   <= n_t1;
            r_z    <= n_z;
            r_flip <= n_flip;
        end
    end

    assign o_valid = r_valid2;
    assign o_z     = r_z;
    assign o_flip  = r_flip;

endmodule

[rtl/dhfk_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_cordic_cell
// One rotation-mode CORDIC iteration, applied to all joint lanes.
// ----------------------------------------------------------------------------
module dhfk_cordic_cell import dhfk_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_lane                 i_x,
    input  t_lane                 i_y,
    input  t_lane                 i_z,
    input  logic [NUM_JOINTS-1:0] i_flip,
    output logic                  o_valid,
    output t_lane                 o_x,
    output t_lane                 o_y,
    output t_lane                 o_z,
    output logic [NUM_JOINTS-1:0] o_flip
);

    localparam t_q28 ATAN_STEP = ATAN_Q28[STEP];

    logic                  r_valid;
    t_lane                 r_x, r_y, r_z, n_x, n_y, n_z;
    logic [NUM_JOINTS-1:0] r_flip;

    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            if (i_z[j] >= 0) begin
                n_x[j] = i_x[j] - (i_y[j] >>> STEP);
                n_y[j] = i_y[j] + (i_x[j] >>> STEP);
                n_z[j] = i_z[j] - ATAN_STEP;
            end else begin
                n_x[j] = i_x[j] + (i_y[j] >>> STEP);
                n_y[j] = i_y[j] - (i_x[j] >>> STEP);
                n_z[j] = i_z[j] + ATAN_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_flip <= i_flip;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_flip  = r_flip;

endmodule

[rtl/dhfk_link.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_link
// Chains one joint transform onto the running pose in four stages:
// products, rotation sums, position products, position sums.
// ----------------------------------------------------------------------------
module dhfk_link import dhfk_pkg::*; #(
    parameter int JOINT = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_rot  i_rot,
    input  t_vec  i_pos,
    input  t_lane i_sin,
    input  t_lane i_cos,
    input  t_pos  i_len_a,
    input  t_pos  i_len_d,
    output logic  o_valid,
    output t_rot  o_rot,
    output t_vec  o_pos,
    output t_lane o_sin,
    output t_lane o_cos
);

    localparam logic signed [1:0] CA = JOINT_CA[JOINT];
    localparam logic signed [1:0] SA = JOINT_SA[JOINT];

    typedef logic signed [63:0] t_p64;
    typedef logic signed [64:0] t_p65;

    // stage A
    logic  r_a_valid;
    t_p64  r_a_p0c [3], r_a_p0s [3], r_a_p1c [3], r_a_p1s [3];
    t_p64  n_a_p0c [3], n_a_p0s [3], n_a_p1c [3], n_a_p1s [3];
    t_p65  r_a_ac, r_a_as, n_a_ac, n_a_as;
    t_rot  r_a_rot;
    t_vec  r_a_pos;
    t_lane r_a_sin, r_a_cos;
    // stage B
    logic  r_b_valid;
    t_rot  r_b_res, n_b_res, r_b_rot;
    t_pos  r_b_np0, r_b_np1, n_b_np0, n_b_np1;
    t_vec  r_b_pos;
    t_lane r_b_sin, r_b_cos;
    // stage C
    logic  r_c_valid;
    t_p65  r_c_q [3][3], n_c_q [3][3];
    t_rot  r_c_res;
    t_vec  r_c_pos;
    t_lane r_c_sin, r_c_cos;
    // stage D
    logic  r_d_valid;
    t_rot  r_d_res;
    t_vec  r_d_pos, n_d_pos;
    t_lane r_d_sin, r_d_cos;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_p0c[i] = i_rot[i][0] * i_cos[JOINT];
            n_a_p0s[i] = i_rot[i][0] * i_sin[JOINT];
            n_a_p1c[i] = i_rot[i][1] * i_cos[JOINT];
            n_a_p1s[i] = i_rot[i][1] * i_sin[JOINT];
        end
        n_a_ac = i_len_a * i_cos[JOINT];
        n_a_as = i_len_a * i_sin[JOINT];
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [65:0] d10;
            logic signed [65:0] acc2;
            d10  = 66'(r_a_p1c[i]) - 66'(r_a_p0s[i]);
            acc2 = 66'(r_a_rot[i][2]) <<< 28;
            n_b_res[i][0] = rnd_q28(67'(r_a_p0c[i]) + 67'(r_a_p1s[i]));
            n_b_res[i][1] = rnd_q28(67'(apply_sign(CA, d10)) + 67'(apply_sign(SA, acc2)));
            n_b_res[i][2] = rnd_q28(67'(apply_sign(SA, -d10)) + 67'(apply_sign(CA, acc2)));
        end
        n_b_np0 = rnd_pos(67'(r_a_ac));
        n_b_np1 = rnd_pos(67'(r_a_as));
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c_q[i][0] = r_b_rot[i][0] * r_b_np0;
            n_c_q[i][1] = r_b_rot[i][1] * r_b_np1;
            n_c_q[i][2] = r_b_rot[i][2] * i_len_d;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d_pos[i] = r_c_pos[i]
                       + rnd_pos(67'(r_c_q[i][0]) + 67'(r_c_q[i][1]) + 67'(r_c_q[i][2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_p0c <= n_a_p0c;
            r_a_p0s <= n_a_p0s;
            r_a_p1c <= n_a_p1c;
            r_a_p1s <= n_a_p1s;
            r_a_ac  <= n_a_ac;
            r_a_as  <= n_a_as;
            r_a_rot <= i_rot;
            r_a_pos <= i_pos;
            r_a_sin <= i_sin;
            r_a_cos <= i_cos;

            r_b_res <= n_b_res;
            r_b_np0 <= n_b_np0;
            r_b_np1 <= n_b_np1;
            r_b_rot <= r_a_rot;
            r_b_pos <= r_a_pos;
            r_b_sin <= r_a_sin;
            r_b_cos <= r_a_cos;

            r_c_q   <= n_c_q;
            r_c_res <= r_b_res;
            r_c_pos <= r_b_pos;
            r_c_sin <= r_b_sin;
            r_c_cos <= r_b_cos;

            r_d_res <= r_c_res;
            r_d_pos <= n_d_pos;
            r_d_sin <= r_c_sin;
            r_d_cos <= r_c_cos;
        end
    end

    assign o_valid = r_d_valid;
    assign o_rot   = r_d_res;
    assign o_pos   = r_d_pos;
    assign o_sin   = r_d_sin;
    assign o_cos   = r_d_cos;

endmodule

[rtl/dh_forward_kinematics_6dof.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dh_forward_kinematics_6dof
// Six-joint DH forward kinematics: angle fold, CORDIC cell chain, six link
// cells chaining the joint transforms, rounding and saturation of the pose.
// ----------------------------------------------------------------------------
// Pipeline: 2 fold stages, one cell per CORDIC iteration, 4 stages per link,
// 1 output register. Throughput: one request per cycle unless i_stall holds
// a valid result; the whole pipe advances together and a one-entry skid
// register decouples the input stall from the output stall.
// Reset: synchronous, active low; clears valid bits, skid and config registers.
module dh_forward_kinematics_6dof import dhfk_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [ANG_W-1:0] i_angle_one,
    input  logic signed [ANG_W-1:0] i_angle_two,
    input  logic signed [ANG_W-1:0] i_angle_three,
    input  logic signed [ANG_W-1:0] i_angle_four,
    input  logic signed [ANG_W-1:0] i_angle_five,
    input  logic signed [ANG_W-1:0] i_angle_six,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [ROT_W-1:0] o_rot_11,
    output logic signed [ROT_W-1:0] o_rot_12,
    output logic signed [ROT_W-1:0] o_rot_13,
    output logic signed [ROT_W-1:0] o_rot_21,
    output logic signed [ROT_W-1:0] o_rot_22,
    output logic signed [ROT_W-1:0] o_rot_23,
    output logic signed [ROT_W-1:0] o_rot_31,
    output logic signed [ROT_W-1:0] o_rot_32,
    output logic signed [ROT_W-1:0] o_rot_33,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [POS_W-1:0] o_pos_z
);

    typedef logic signed [ROT_W-1:0] t_rot_out;
    typedef logic signed [POS_W-1:0] t_pos_out;

    // configuration
    logic [LEN_W-1:0] r_cfg [NUM_REGS];
    logic [2:0]       cfg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (cfg_wr && (cfg_idx < 3'(NUM_REGS))) begin
            r_cfg[cfg_idx] <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        if (cfg_idx < 3'(NUM_REGS)) begin
            prdata = {{(32-LEN_W){1'b0}}, r_cfg[cfg_idx]};
        end else begin
            prdata = '0;
        end
    end

    t_pos len_a [NUM_JOINTS];
    t_pos len_d [NUM_JOINTS];

    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            len_a[j] = '0;
            len_d[j] = '0;
        end
        len_d[0] = t_pos'({r_cfg[REG_BASE_HEIGHT], 4'b0});
        len_a[0] = t_pos'({r_cfg[REG_SHOULDER_OFFSET], 4'b0});
        len_a[1] = t_pos'({r_cfg[REG_UPPER_ARM_LENGTH], 4'b0});
        len_a[2] = t_pos'({r_cfg[REG_ELBOW_OFFSET], 4'b0});
        len_d[3] = t_pos'({r_cfg[REG_FOREARM_LENGTH], 4'b0});
        len_d[5] = t_pos'({r_cfg[REG_TOOL_LENGTH], 4'b0});
    end

    // flow control and skid
    logic      en, in_take, head_valid;
    logic      r_skid_valid;
    t_ang_lane r_skid_ang, in_ang, head_ang;
    logic      r_out_valid;

    assign en         = !r_out_valid || !i_stall;
    assign in_take    = i_valid && !r_skid_valid;
    assign head_valid = r_skid_valid || in_take;
    assign o_stall    = r_skid_valid;

    always_comb begin
        in_ang[0] = i_angle_one;
        in_ang[1] = i_angle_two;
        in_ang[2] = i_angle_three;
        in_ang[3] = i_angle_four;
        in_ang[4] = i_angle_five;
        in_ang[5] = i_angle_six;
        head_ang  = r_skid_valid ? r_skid_ang : in_ang;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (en) begin
            r_skid_valid <= 1'b0;
        end else if (in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && in_take) begin
            r_skid_ang <= in_ang;
        end
    end

    // angle fold
    logic                  fold_valid;
    t_lane                 fold_z;
    logic [NUM_JOINTS-1:0] fold_flip;

    dhfk_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (head_valid),
        .i_ang   (head_ang),
        .o_valid (fold_valid),
        .o_z     (fold_z),
        .o_flip  (fold_flip)
    );

    // CORDIC chain
    logic                  cv    [CORDIC_STEPS+1];
    t_lane                 cx    [CORDIC_STEPS+1];
    t_lane                 cy    [CORDIC_STEPS+1];
    t_lane                 cz    [CORDIC_STEPS+1];
    logic [NUM_JOINTS-1:0] cflip [CORDIC_STEPS+1];

    always_comb begin
        cv[0]    = fold_valid;
        cz[0]    = fold_z;
        cflip[0] = fold_flip;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            cx[0][j] = Q28_GAIN;
            cy[0][j] = '0;
        end
    end

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
        dhfk_cordic_cell #(.STEP(s)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cv[s]),
            .i_x     (cx[s]),
            .i_y     (cy[s]),
            .i_z     (cz[s]),
            .i_flip  (cflip[s]),
            .o_valid (cv[s+1]),
            .o_x     (cx[s+1]),
            .o_y     (cy[s+1]),
            .o_z     (cz[s+1]),
            .o_flip  (cflip[s+1])
        );
    end

    // link chain
    logic  lv   [NUM_JOINTS+1];
    t_rot  lrot [NUM_JOINTS+1];
    t_vec  lpos [NUM_JOINTS+1];
    t_lane lsin [NUM_JOINTS];
    t_lane lcos [NUM_JOINTS];

    always_comb begin
        lv[0] = cv[CORDIC_STEPS];
        for (int j = 0; j < NUM_JOINTS; j++) begin
            lsin[0][j] = cflip[CORDIC_STEPS][j] ? -cy[CORDIC_STEPS][j] : cy[CORDIC_STEPS][j];
            lcos[0][j] = cflip[CORDIC_STEPS][j] ? -cx[CORDIC_STEPS][j] : cx[CORDIC_STEPS][j];
        end
        for (int i = 0; i < 3; i++) begin
            lpos[0][i] = '0;
            for (int k = 0; k < 3; k++) begin
                lrot[0][i][k] = (i == k) ? Q28_ONE : '0;
            end
        end
    end

    for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_link
        if (j < NUM_JOINTS - 1) begin : g_mid
            dhfk_link #(.JOINT(j)) u_link (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (lv[j]),
                .i_rot   (lrot[j]),
                .i_pos   (lpos[j]),
                .i_sin   (lsin[j]),
                .i_cos   (lcos[j]),
                .i_len_a (len_a[j]),
                .i_len_d (len_d[j]),
                .o_valid (lv[j+1]),
                .o_rot   (lrot[j+1]),
                .o_pos   (lpos[j+1]),
                .o_sin   (lsin[j+1]),
                .o_cos   (lcos[j+1])
            );
        end else begin : g_last
            dhfk_link #(.JOINT(j)) u_link (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (lv[j]),
                .i_rot   (lrot[j]),
                .i_pos   (lpos[j]),
                .i_sin   (lsin[j]),
                .i_cos   (lcos[j]),
                .i_len_a (len_a[j]),
                .i_len_d (len_d[j]),
                .o_valid (lv[j+1]),
                .o_rot   (lrot[j+1]),
                .o_pos   (lpos[j+1]),
                .o_sin   (),
                .o_cos   ()
            );
        end
    end

    // output rounding and saturation
    t_rot_out r_out_rot [3][3], n_out_rot [3][3];
    t_pos_out r_out_pos [3],    n_out_pos [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                t_q28               t;
                logic signed [19:0] v;
                t = lrot[NUM_JOINTS][i][k] + 32'sd2048;
                v = t[31:12];
                if (v > 20'sd65536) begin
                    n_out_rot[i][k] = 18'sd65536;
                end else if (v < -20'sd65536) begin
                    n_out_rot[i][k] = -18'sd65536;
                end else begin
                    n_out_rot[i][k] = t_rot_out'(v);
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            t_pos               t;
            logic signed [28:0] v;
            t = lpos[NUM_JOINTS][i] + 33'sd8;
            v = t[32:4];
            if (v > 29'sd134217727) begin
                n_out_pos[i] = 28'sd134217727;
            end else if (v < -29'sd134217728) begin
                n_out_pos[i] = -28'sd134217728;
            end else begin
                n_out_pos[i] = t_pos_out'(v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= lv[NUM_JOINTS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_rot <= n_out_rot;
            r_out_pos <= n_out_pos;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_rot_11 = r_out_rot[0][0];
    assign o_rot_12 = r_out_rot[0][1];
    assign o_rot_13 = r_out_rot[0][2];
    assign o_rot_21 = r_out_rot[1][0];
    assign o_rot_22 = r_out_rot[1][1];
    assign o_rot_23 = r_out_rot[1][2];
    assign o_rot_31 = r_out_rot[2][0];
    assign o_rot_32 = r_out_rot[2][1];
    assign o_rot_33 = r_out_rot[2][2];
    assign o_pos_x  = r_out_pos[0];
    assign o_pos_y  = r_out_pos[1];
    assign o_pos_z  = r_out_pos[2];

endmodule

[rtl/dhfk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhfk_checker
// Port-level checks on the kinematics core: output hold, rotation range and
// skid register behavior.
// ----------------------------------------------------------------------------
module dhfk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [17:0] o_rot_11,
    input logic signed [17:0] o_rot_22
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rot_11))
        else $error("result dropped or changed while stalled");

    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rot_11 <= 18'sd65536) && (o_rot_11 >= -18'sd65536)
                 && (o_rot_22 <= 18'sd65536) && (o_rot_22 >= -18'sd65536))
        else $error("rotation entry outside clamp range");

    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid && o_valid && i_stall))
        else $error("input stall raised without a stalled result");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !(o_valid && i_stall) |=> !o_stall)
        else $error("skid request not drained");

endmodule

bind dh_forward_kinematics_6dof dhfk_checker u_dhfk_checker (.*);
